// File: hdl/deque_with_search_core_assert.svh
// Assertion macros for the checker file.
`ifndef DEQUE_WITH_SEARCH_CORE_ASSERT_SVH
`define DEQUE_WITH_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled during reset.
`define DQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: hdl/dqs_pkg.sv
package dqs_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_FINISH
    } t_state;

    // Ring slot at an offset from idx; idx < DEPTH and off <= DEPTH.
    function automatic t_idx ring_add(input t_idx idx, input t_cnt off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(idx) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic t_idx ring_dec(input t_idx idx);
        t_idx r;
        if (idx == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = idx - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/deque_with_search_core.sv
// Bounded double-ended queue of 32-bit items held in a ring in one
// dual-port RAM (one write, one registered read), with a front index and
// a fill count in flip-flops. One command is taken at a time; each gives
// exactly one result. A push writes one RAM slot (none on a full queue), a pop
// does one RAM read (none on an empty queue), and a search compares k
// entries, where k is none on an empty queue, else 1 to the count: the
// single read port fetches one entry a cycle from the front. Results sit
// in an output register, so the next command is taken while a result is
// still stalled.
module deque_with_search_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_item_value,
    output logic [3:0]         o_position,
    output logic [4:0]         o_item_count
);
    import dqs_pkg::*;

    t_state              r_state, n_state;
    t_idx                r_front, n_front;
    t_cnt                r_count, n_count;
    logic [2:0]          r_cmd;
    logic [DATA_W-1:0]   r_val;
    t_idx                r_scan, n_scan;
    t_status             r_res_status, n_res_status;
    logic [DATA_W-1:0]   r_res_item, n_res_item;
    t_idx                r_res_pos, n_res_pos;

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [DATA_W-1:0]   r_o_item;
    logic [3:0]          r_o_pos;
    logic [4:0]          r_o_count;

    logic                ram_we;
    t_idx                ram_waddr;
    t_idx                ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                is_full;
    logic                is_empty;
    t_cnt                scan_next;
    logic [31:0]         pos_ext;
    logic [31:0]         cnt_ext;

    dqs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_val),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign load_out  = (r_state == S_FINISH) && out_free;
    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign scan_next = CNT_W'(r_scan) + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_scan       = r_scan;
        n_res_status = r_res_status;
        n_res_item   = r_res_item;
        n_res_pos    = r_res_pos;
        ram_we       = 1'b0;
        ram_waddr    = r_front;
        ram_raddr    = r_front;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state      = S_EXEC;
                    n_res_status = ST_OK;
                    n_res_item   = '0;
                    n_res_pos    = '0;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                unique case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (is_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = ring_dec(r_front);
                            n_front   = ring_dec(r_front);
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (is_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = ring_add(r_front, r_count);
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (is_empty) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            ram_raddr = r_front;
                            n_front   = ring_add(r_front, CNT_W'(1));
                            n_count   = r_count - CNT_W'(1);
                            n_state   = S_READ;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (is_empty) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            ram_raddr = ring_add(r_front, r_count - CNT_W'(1));
                            n_count   = r_count - CNT_W'(1);
                            n_state   = S_READ;
                        end
                    end
                    CMD_SEARCH: begin
                        if (is_empty) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            ram_raddr = r_front;
                            n_scan    = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                n_res_item = ram_rdata;
                n_state    = S_FINISH;
            end
            S_SCAN: begin
                ram_raddr = ring_add(r_front, scan_next);
                if (ram_rdata == r_val) begin
                    n_res_item = r_val;
                    n_res_pos  = r_scan;
                    n_state    = S_FINISH;
                end else if (scan_next == r_count) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_FINISH;
                end else begin
                    n_scan = scan_next[IDX_W-1:0];
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign pos_ext = 32'(r_res_pos);
    assign cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        r_scan       <= n_scan;
        r_res_status <= n_res_status;
        r_res_item   <= n_res_item;
        r_res_pos    <= n_res_pos;
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_item   <= r_res_item;
            r_o_pos    <= pos_ext[3:0];
            r_o_count  <= cnt_ext[4:0];
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_item_value = r_o_item;
    assign o_position   = r_o_pos;
    assign o_item_count = r_o_count;

endmodule

// File: hdl/dqs_ram.sv
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dqs_checker.sv
`include "deque_with_search_core_assert.svh"

module dqs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_command,
    input logic signed [31:0] i_value,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_item_value,
    input logic [3:0]         o_position,
    input logic [4:0]         o_item_count
);
    import dqs_pkg::*;

    `DQS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `DQS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_out_valid, 32'(o_item_count) <= DEPTH)
    `DQS_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), (o_item_value == '0) && (o_position == '0))
    `DQS_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL), 32'(o_item_count) == DEPTH)
    `DQS_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY), o_item_count == '0)

endmodule

bind deque_with_search_core dqs_checker u_dqs_checker (.*);
